// ===== hw/rtl/smm_pkg.sv =====
package smm_pkg;

  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_SET_VEL = 1'b1;

  typedef enum logic [2:0] {
    REG_CONST_FORCE_X   = 3'd0,
    REG_CONST_FORCE_Y   = 3'd1,
    REG_SPRING_CENTER_X = 3'd2,
    REG_SPRING_CENTER_Y = 3'd3,
    REG_SPRING_K        = 3'd4,
    REG_INVERSE_MASS    = 3'd5,
    REG_Y_FLOOR         = 3'd6,
    REG_Y_CEILING       = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFF,
    ST_MK,
    ST_FORCE,
    ST_MM,
    ST_ACCL,
    ST_MT,
    ST_VEL,
    ST_DMUL,
    ST_DSAT,
    ST_NY,
    ST_CLAMP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_Z
  } sel_t;

  typedef struct packed {
    logic               func;
    logic [15:0]        time_step;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic               moved;
  } out_res_t;

  typedef struct packed {
    logic signed [31:0] const_force_x;
    logic signed [31:0] const_force_y;
    logic signed [31:0] spring_center_x;
    logic signed [31:0] spring_center_y;
    logic [30:0]        spring_k;
    logic [30:0]        inverse_mass;
    logic signed [31:0] y_floor;
    logic signed [31:0] y_ceiling;
  } cfg_t;

  typedef struct packed {
    logic               mul_en;
    logic signed [31:0] mul_a;
    logic [30:0]        mul_b;
    logic signed [31:0] add_a;
    logic signed [31:0] add_b;
    logic               add_sub;
    logic               use_scaled;
  } alu_ctl_t;

endpackage

// ===== hw/rtl/smm_alu.sv =====
module smm_alu
  import smm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  alu_ctl_t           ctl,
  output logic signed [31:0] scaled,
  output logic signed [31:0] sum
);

  logic signed [63:0] prod_r;
  logic signed [63:0] prod_nxt;
  logic signed [63:0] shifted;
  logic signed [31:0] mul_b_s;
  logic signed [31:0] opb;
  logic [32:0]        ext_a;
  logic [32:0]        ext_b;
  logic [32:0]        sum33;

  assign mul_b_s  = $signed({1'b0, ctl.mul_b});
  assign prod_nxt = ctl.mul_a * mul_b_s;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // floor shift of the product, then saturate to 32 bits
  assign shifted = prod_r >>> FRAC_BITS;

  always_comb begin
    if ((&shifted[63:31]) || !(|shifted[63:31])) begin
      scaled = shifted[31:0];
    end else if (shifted[63]) begin
      scaled = S32_MIN;
    end else begin
      scaled = S32_MAX;
    end
  end

  assign opb   = ctl.use_scaled ? scaled : ctl.add_b;
  assign ext_a = {ctl.add_a[31], ctl.add_a};
  assign ext_b = {opb[31], opb};
  assign sum33 = ctl.add_sub ? (ext_a - ext_b) : (ext_a + ext_b);

  always_comb begin
    if (sum33[32] == sum33[31]) begin
      sum = sum33[31:0];
    end else if (sum33[32]) begin
      sum = S32_MIN;
    end else begin
      sum = S32_MAX;
    end
  end

endmodule

// ===== hw/rtl/smm_seq.sv =====
module smm_seq
  import smm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_req_t            in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output out_res_t           out_res,
  output alu_ctl_t           alu_ctl,
  input  logic signed [31:0] alu_scaled,
  input  logic signed [31:0] alu_sum
);

  state_t             state_r, state_nxt;
  sel_t               sel_r, sel_nxt;
  in_req_t            req_r, req_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] vel_x_r, vel_x_nxt;
  logic signed [31:0] vel_y_r, vel_y_nxt;
  logic signed [31:0] vel_z_r, vel_z_nxt;
  logic signed [31:0] dx_r, dx_nxt;
  logic signed [31:0] dy_r, dy_nxt;
  logic signed [31:0] dz_r, dz_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_res_t           out_res_r, out_res_nxt;

  logic signed [31:0] pos_sel;
  logic signed [31:0] cen_sel;
  logic signed [31:0] cf_sel;
  logic signed [31:0] vel_sel;
  logic               below;
  logic               above;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    unique case (sel_r)
      SEL_X: begin
        pos_sel = req_r.pos_x;
        cen_sel = cfg.spring_center_x;
        cf_sel  = cfg.const_force_x;
        vel_sel = vel_x_r;
      end
      SEL_Y: begin
        pos_sel = req_r.pos_y;
        cen_sel = cfg.spring_center_y;
        cf_sel  = cfg.const_force_y;
        vel_sel = vel_y_r;
      end
      default: begin
        pos_sel = req_r.pos_y;
        cen_sel = cfg.spring_center_y;
        cf_sel  = cfg.const_force_y;
        vel_sel = vel_z_r;
      end
    endcase
  end

  assign below = (cfg.y_floor != S32_MIN) && (acc_r < cfg.y_floor);
  assign above = (cfg.y_ceiling != S32_MAX) && (acc_r > cfg.y_ceiling);

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    req_nxt       = req_r;
    acc_nxt       = acc_r;
    vel_x_nxt     = vel_x_r;
    vel_y_nxt     = vel_y_r;
    vel_z_nxt     = vel_z_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dz_nxt        = dz_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    alu_ctl       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req;
          if (in_req.func == FUNC_SET_VEL) begin
            vel_x_nxt = in_req.new_vel_x;
            vel_y_nxt = in_req.new_vel_y;
            vel_z_nxt = in_req.new_vel_z;
          end else begin
            sel_nxt   = SEL_X;
            state_nxt = ST_OFF;
          end
        end
      end
      ST_OFF: begin
        alu_ctl.add_a   = pos_sel;
        alu_ctl.add_b   = cen_sel;
        alu_ctl.add_sub = 1'b1;
        acc_nxt         = alu_sum;
        state_nxt       = ST_MK;
      end
      ST_MK: begin
        alu_ctl.mul_en = 1'b1;
        alu_ctl.mul_a  = acc_r;
        alu_ctl.mul_b  = cfg.spring_k;
        state_nxt      = ST_FORCE;
      end
      ST_FORCE: begin
        alu_ctl.add_a      = cf_sel;
        alu_ctl.add_sub    = 1'b1;
        alu_ctl.use_scaled = 1'b1;
        acc_nxt            = alu_sum;
        state_nxt          = ST_MM;
      end
      ST_MM: begin
        alu_ctl.mul_en = 1'b1;
        alu_ctl.mul_a  = acc_r;
        alu_ctl.mul_b  = cfg.inverse_mass;
        state_nxt      = ST_ACCL;
      end
      ST_ACCL: begin
        acc_nxt   = alu_scaled;
        state_nxt = ST_MT;
      end
      ST_MT: begin
        alu_ctl.mul_en = 1'b1;
        alu_ctl.mul_a  = acc_r;
        alu_ctl.mul_b  = {15'd0, req_r.time_step};
        state_nxt      = ST_VEL;
      end
      ST_VEL: begin
        alu_ctl.add_a      = vel_sel;
        alu_ctl.use_scaled = 1'b1;
        if (sel_r == SEL_Y) begin
          vel_y_nxt = alu_sum;
          sel_nxt   = SEL_X;
          state_nxt = ST_DMUL;
        end else begin
          vel_x_nxt = alu_sum;
          sel_nxt   = SEL_Y;
          state_nxt = ST_OFF;
        end
      end
      ST_DMUL: begin
        alu_ctl.mul_en = 1'b1;
        alu_ctl.mul_a  = vel_sel;
        alu_ctl.mul_b  = {15'd0, req_r.time_step};
        state_nxt      = ST_DSAT;
      end
      ST_DSAT: begin
        unique case (sel_r)
          SEL_X: begin
            dx_nxt    = alu_scaled;
            sel_nxt   = SEL_Y;
            state_nxt = ST_DMUL;
          end
          SEL_Y: begin
            dy_nxt    = alu_scaled;
            sel_nxt   = SEL_Z;
            state_nxt = ST_DMUL;
          end
          default: begin
            dz_nxt    = alu_scaled;
            state_nxt = ST_NY;
          end
        endcase
      end
      ST_NY: begin
        alu_ctl.add_a = req_r.pos_y;
        alu_ctl.add_b = dy_r;
        acc_nxt       = alu_sum;
        state_nxt     = ST_CLAMP;
      end
      ST_CLAMP: begin
        // floor has priority over ceiling
        alu_ctl.add_a   = below ? cfg.y_floor : cfg.y_ceiling;
        alu_ctl.add_b   = req_r.pos_y;
        alu_ctl.add_sub = 1'b1;
        if (below || above) begin
          dy_nxt = alu_sum;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_res_nxt.delta_x = dx_r;
          out_res_nxt.delta_y = dy_r;
          out_res_nxt.delta_z = dz_r;
          out_res_nxt.moved   = (dx_r != 32'sd0) || (dy_r != 32'sd0);
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= SEL_X;
      out_valid_r <= 1'b0;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      vel_z_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
      vel_x_r     <= vel_x_nxt;
      vel_y_r     <= vel_y_nxt;
      vel_z_r     <= vel_z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    acc_r     <= acc_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    dz_r      <= dz_nxt;
    out_res_r <= out_res_nxt;
  end

  a_set_vel_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_req.func == FUNC_SET_VEL) |=>
      (state_r == ST_IDLE && vel_x_r == $past(in_req.new_vel_x) &&
       vel_z_r == $past(in_req.new_vel_z)))
    else $error("set velocity request not loaded");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !(out_valid_r && out_stall)) |=>
      (out_valid_r && state_r == ST_IDLE))
    else $error("finished tick not presented");

  a_vel_z_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> (vel_z_r == $past(vel_z_r)))
    else $error("z velocity changed during a tick");

endmodule

// ===== hw/rtl/spring_mass_motion_step.sv =====
// Spring-mass step: a tick request (func 0) updates the stored x and y velocity
// with constant force minus spring force, scaled by inverse mass and time step, and
// returns the x, y, z displacement (velocity times dt, y clamped to the configured
// floor and ceiling) with a moved flag; a set-velocity request (func 1) loads all
// three velocities and returns nothing. All arithmetic is fixed point with
// FRAC_BITS fraction bits, floor-rounded and saturated to 32 bits. One 32x32
// multiplier and one saturating adder are shared under a sequencer: a tick issues
// nine multiplies, each followed by a step that uses the scaled product, plus
// offset, new-y, clamp and hand-off steps; in_stall stays high from acceptance
// until the result is valid. Configuration writes are taken every cycle.
module spring_mass_motion_step
  import smm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_req,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t               cfg_r;
  cfg_t               cfg_nxt;
  alu_ctl_t           alu_ctl;
  logic signed [31:0] alu_scaled;
  logic signed [31:0] alu_sum;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_CONST_FORCE_X:   cfg_nxt.const_force_x   = cfg_data;
        REG_CONST_FORCE_Y:   cfg_nxt.const_force_y   = cfg_data;
        REG_SPRING_CENTER_X: cfg_nxt.spring_center_x = cfg_data;
        REG_SPRING_CENTER_Y: cfg_nxt.spring_center_y = cfg_data;
        REG_SPRING_K:        cfg_nxt.spring_k        = cfg_data[30:0];
        REG_INVERSE_MASS:    cfg_nxt.inverse_mass    = cfg_data[30:0];
        REG_Y_FLOOR:         cfg_nxt.y_floor         = cfg_data;
        REG_Y_CEILING:       cfg_nxt.y_ceiling       = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.const_force_x   <= '0;
      cfg_r.const_force_y   <= '0;
      cfg_r.spring_center_x <= '0;
      cfg_r.spring_center_y <= '0;
      cfg_r.spring_k        <= '0;
      cfg_r.inverse_mass    <= 31'd65536;
      cfg_r.y_floor         <= S32_MIN;
      cfg_r.y_ceiling       <= S32_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  smm_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk    (clk),
    .ctl    (alu_ctl),
    .scaled (alu_scaled),
    .sum    (alu_sum)
  );

  smm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res),
    .alu_ctl    (alu_ctl),
    .alu_scaled (alu_scaled),
    .alu_sum    (alu_sum)
  );

endmodule
